FILE: rtl/core/isul_pkg.sv
// Shared types, constants and helpers for the Ising lattice update unit.
package isul_pkg;

  // Default largest lattice side.
  localparam int SIDE_MAX_DEF = 64;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int RAND_W  = 12;
  localparam int SIDE_W  = 7;
  localparam int H_W     = 12;
  localparam int TBL_W   = 60;
  localparam int THR_W   = 12;
  localparam int CFG_IDX_W = 3;

  // Commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_METRO = 2'd2,
    CMD_HEAT  = 2'd3
  } command_t;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIDE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_H    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_METRO_UP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_METRO_DOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT       = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;  // clear one write flag entry
    logic latch_in;    // capture an accepted input transfer
    logic sel_center;  // read site and upper neighbor
    logic sel_mid;     // capture first pair, read lower and left
    logic sel_last;    // capture second pair, read right
    logic finish;      // update the site and load the result register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;  // last write flag entry is being cleared
  } dp_stat_t;

  // Pick threshold k out of a packed table of five 12-bit entries.
  function automatic logic [THR_W-1:0] table_entry(input logic [TBL_W-1:0] tbl,
                                                   input logic [2:0] k);
    logic [THR_W-1:0] res;
    begin
      case (k)
        3'd0:    res = tbl[11:0];
        3'd1:    res = tbl[23:12];
        3'd2:    res = tbl[35:24];
        3'd3:    res = tbl[47:36];
        3'd4:    res = tbl[59:48];
        default: res = '0;
      endcase
      return res;
    end
  endfunction

endpackage

FILE: rtl/core/isul_ctrl.sv
// Controller state machine for the Ising lattice update unit.
module isul_ctrl
  import isul_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD0   = 6'b000100,
    ST_RD1   = 6'b001000,
    ST_RD2   = 6'b010000,
    ST_EXEC  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: in_ready = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.latch_in   = accept;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.sel_center = (state == ST_RD0);
    cmd.sel_mid    = (state == ST_RD1);
    cmd.sel_last   = (state == ST_RD2);
    cmd.finish     = (state == ST_EXEC) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_RD0;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (out_free) state_next = accept ? ST_RD0 : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/isul_datapath.sv
// Lattice memories, neighbor addressing and spin update datapath.
module isul_datapath
  import isul_pkg::*;
#(
  parameter int SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [CMD_W-1:0]        command,
  input  logic [COORD_W-1:0]      row,
  input  logic [COORD_W-1:0]      col,
  input  logic                    spin_in,
  input  logic [RAND_W-1:0]       rand_value,
  input  logic [SIDE_W-1:0]       lattice_side,
  input  logic                    fixed_boundary,
  input  logic signed [H_W-1:0]   field_h,
  input  logic [TBL_W-1:0]        metro_table_up,
  input  logic [TBL_W-1:0]        metro_table_down,
  input  logic [TBL_W-1:0]        heat_table,
  output logic                    spin_out,
  output logic                    changed,
  output logic                    bad_site
);

  localparam int DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SIDE_MAX);
  localparam int SW    = ($clog2(SIDE_MAX + 1) > SIDE_W) ? $clog2(SIDE_MAX + 1) : SIDE_W;

  // Storage
  logic spin_mem    [DEPTH];
  logic written_mem [DEPTH];

  // Latched transfer
  command_t           cmd_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic               spin_in_q;
  logic [RAND_W-1:0]  rand_q;

  logic [AW-1:0] clr_addr;

  logic [SW-1:0] side_ext, n;
  logic          outside;
  logic [CW-1:0] rr, cc, nm1, up, dn, lf, rt;
  logic [AW-1:0] addr_c, addr_up, addr_dn, addr_lf, addr_rt;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic          rd_a, rd_b, rd_w;
  logic          s_center, w_center, s_up, s_dn, s_lf;

  logic [2:0]           k;
  logic signed [12:0]   h13, term, energy;
  logic                 forced, on_edge, flip;
  logic [THR_W-1:0]     thr_metro, thr_heat;
  logic                 new_spin, do_write, set_flag;
  logic                 res_spin, res_changed, res_bad;

  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(SIDE_MAX) + AW'(c));
  endfunction

  // Side in use, clamped to [3, SIDE_MAX]
  always_comb begin
    side_ext = SW'(lattice_side);
    if (side_ext < SW'(3)) begin
      n = SW'(3);
    end else if (side_ext > SW'(SIDE_MAX)) begin
      n = SW'(SIDE_MAX);
    end else begin
      n = side_ext;
    end
  end

  assign outside = (SW'(row_q) >= n) || (SW'(col_q) >= n);

  // Neighbor coordinates with periodic wrap; fixed mode only steps interior sites
  assign rr  = CW'(row_q);
  assign cc  = CW'(col_q);
  assign nm1 = CW'(n - SW'(1));
  assign up  = (rr == '0)  ? nm1 : CW'(rr - CW'(1));
  assign dn  = (rr == nm1) ? '0  : CW'(rr + CW'(1));
  assign lf  = (cc == '0)  ? nm1 : CW'(cc - CW'(1));
  assign rt  = (cc == nm1) ? '0  : CW'(cc + CW'(1));

  assign addr_c  = site_addr(rr, cc);
  assign addr_up = site_addr(up, cc);
  assign addr_dn = site_addr(dn, cc);
  assign addr_lf = site_addr(rr, lf);
  assign addr_rt = site_addr(rr, rt);

  always_comb begin
    if (cmd.sel_center) begin
      rd_addr_a = addr_c;
      rd_addr_b = addr_up;
    end else if (cmd.sel_mid) begin
      rd_addr_a = addr_dn;
      rd_addr_b = addr_lf;
    end else begin
      rd_addr_a = addr_rt;
      rd_addr_b = addr_rt;
    end
  end

  // Memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    rd_a <= spin_mem[rd_addr_a];
    rd_b <= spin_mem[rd_addr_b];
    if (do_write) begin
      spin_mem[addr_c] <= new_spin;
    end
  end

  always_ff @(posedge clk) begin
    rd_w <= written_mem[rd_addr_a];
    if (cmd.clear_step) begin
      written_mem[clr_addr] <= 1'b0;
    end else if (set_flag) begin
      written_mem[addr_c] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !stat.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign stat.clear_done = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_q     <= command_t'(command);
      row_q     <= row;
      col_q     <= col;
      spin_in_q <= spin_in;
      rand_q    <= rand_value;
    end
    if (cmd.sel_mid) begin
      s_center <= rd_a;
      w_center <= rd_w;
      s_up     <= rd_b;
    end
    if (cmd.sel_last) begin
      s_dn <= rd_a;
      s_lf <= rd_b;
    end
  end

  // Update decision; the right neighbor is still in the read register
  assign k = 3'(s_up) + 3'(s_dn) + 3'(s_lf) + 3'(rd_a);

  assign h13    = {field_h[H_W-1], field_h};
  assign term   = $signed({1'b0, k, 9'b0}) - 13'sd1024;
  assign energy = h13 + term;
  // Flip is forced when s*(h+S) is negative
  assign forced = s_center ? energy[12] : (!energy[12] && (energy != '0));

  assign thr_metro = table_entry(s_center ? metro_table_up : metro_table_down, k);
  assign thr_heat  = table_entry(heat_table, k);
  assign flip      = forced || (rand_q < thr_metro);

  assign on_edge = (rr == '0) || (cc == '0) || (rr == nm1) || (cc == nm1);

  always_comb begin
    new_spin    = s_center;
    do_write    = 1'b0;
    set_flag    = 1'b0;
    res_spin    = s_center;
    res_changed = 1'b0;
    res_bad     = 1'b0;
    if (outside) begin
      res_spin = 1'b0;
      res_bad  = 1'b1;
    end else begin
      unique case (cmd_q)
        CMD_WRITE: begin
          new_spin    = spin_in_q;
          do_write    = cmd.finish;
          set_flag    = cmd.finish;
          res_spin    = spin_in_q;
          res_changed = !w_center || (s_center != spin_in_q);
        end
        CMD_READ: begin
          res_spin = s_center;
        end
        CMD_METRO, CMD_HEAT: begin
          if (fixed_boundary && on_edge) begin
            res_bad = 1'b1;
          end else begin
            new_spin    = (cmd_q == CMD_METRO) ? (s_center ^ flip) : (rand_q < thr_heat);
            do_write    = cmd.finish;
            res_spin    = new_spin;
            res_changed = new_spin != s_center;
          end
        end
        default: res_bad = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      spin_out <= res_spin;
      changed  <= res_changed;
      bad_site <= res_bad;
    end
  end

endmodule

FILE: rtl/core/ising_spin_update_lattice_unit.sv
// Ising lattice update unit: top level with configuration registers.
// Input passes read states RD0, RD1 and RD2, which fetch the site and its four neighbors
// from a lattice memory with two read ports, then EXEC updates and offers the result.
// EXEC waits for a free result register, then takes the next command as it finishes.
// Reset: clears control state and configuration, then sweeps all SIDE_MAX*SIDE_MAX write
// flags (4096 by default) with in_ready low; config writes still land.
module ising_spin_update_lattice_unit
  import isul_pkg::*;
#(
  parameter int SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [COORD_W-1:0]   row,
  input  logic [COORD_W-1:0]   col,
  input  logic                 spin_in,
  input  logic [RAND_W-1:0]    rand_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 spin_out,
  output logic                 changed,
  output logic                 bad_site,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TBL_W-1:0]     cfg_data
);

  // Configuration registers
  logic [SIDE_W-1:0]     lattice_side;
  logic                  fixed_boundary;
  logic signed [H_W-1:0] field_h;
  logic [TBL_W-1:0]      metro_table_up;
  logic [TBL_W-1:0]      metro_table_down;
  logic [TBL_W-1:0]      heat_table;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Decode register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_side     <= SIDE_W'(64);
      fixed_boundary   <= 1'b0;
      field_h          <= '0;
      metro_table_up   <= '0;
      metro_table_down <= '0;
      heat_table       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIDE:       lattice_side     <= cfg_data[SIDE_W-1:0];
        REG_FIXED:      fixed_boundary   <= cfg_data[0];
        REG_FIELD_H:    field_h          <= $signed(cfg_data[H_W-1:0]);
        REG_METRO_UP:   metro_table_up   <= cfg_data;
        REG_METRO_DOWN: metro_table_down <= cfg_data;
        REG_HEAT:       heat_table       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: clear pass, then read site, read neighbors, update
  isul_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Lattice storage and the spin update arithmetic; holds the result register
  isul_datapath #(
    .SIDE_MAX (SIDE_MAX)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .command          (command),
    .row              (row),
    .col              (col),
    .spin_in          (spin_in),
    .rand_value       (rand_value),
    .lattice_side     (lattice_side),
    .fixed_boundary   (fixed_boundary),
    .field_h          (field_h),
    .metro_table_up   (metro_table_up),
    .metro_table_down (metro_table_down),
    .heat_table       (heat_table),
    .spin_out         (spin_out),
    .changed          (changed),
    .bad_site         (bad_site)
  );

endmodule
